// ----- rtl/mpht_pkg.sv -----
// Package for the MAC-to-port hash table: sizes, codes, sequencer types and helpers.
`default_nettype none

package mpht_pkg;

	// Table geometry
	localparam int TABLE_SIZE = 10;
	localparam int KEY_BYTES  = 5;
	localparam int PORT_BITS  = 8;
	localparam int PROBE_STEP = 7;

	// Fixed field widths of the stream payload
	localparam int KEY_FIELD_W  = 40;
	localparam int PORT_FIELD_W = 8;
	localparam int SLOT_FIELD_W = 4;
	localparam int STAT_W       = 2;
	localparam int S_TDATA_W    = 48;
	localparam int M_TDATA_W    = 16;

	// Derived sizes
	localparam int KEY_USE   = (KEY_BYTES < KEY_FIELD_W / 8) ? KEY_BYTES : KEY_FIELD_W / 8;
	localparam int KEY_W     = 8 * KEY_USE;
	localparam int PORT_KEEP = (PORT_BITS < PORT_FIELD_W) ? PORT_BITS : PORT_FIELD_W;
	localparam int SLOT_W    = $clog2(TABLE_SIZE);
	localparam int CNT_W     = $clog2(TABLE_SIZE + 1);
	localparam int BYTE_W    = (KEY_USE > 1) ? $clog2(KEY_USE) : 1;
	localparam int STEP_MOD  = PROBE_STEP % TABLE_SIZE;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		RES_OK   = 2'd0,
		RES_MISS = 2'd1,
		RES_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_DONE
	} state_t;

	// Control word from the sequencer decode to the datapath
	typedef struct packed {
		logic    take;
		logic    hash_en;
		logic    probe_en;
		logic    wr_en;
		logic    res_en;
		logic    res_hit;
		status_t res_status;
		logic    out_load;
	} ctl_t;

	// Byte reduced modulo the table size: restoring subtract, one bit of quotient a step
	function automatic logic [SLOT_W-1:0] byte_mod(input logic [7:0] b);
		logic [15:0] r;
		r = {8'd0, b};
		for (int j = 7; j >= 0; j--) begin
			if (r >= 16'(TABLE_SIZE << j))
				r = r - 16'(TABLE_SIZE << j);
		end
		return r[SLOT_W-1:0];
	endfunction

	// Add two residues and fold back once into range
	function automatic logic [SLOT_W-1:0] mod_add(input logic [SLOT_W-1:0] a,
		input logic [SLOT_W-1:0] b);
		logic [SLOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (SLOT_W+1)'(TABLE_SIZE))
			s = s - (SLOT_W+1)'(TABLE_SIZE);
		return s[SLOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/mac_port_hash_table.sv -----
// MAC-to-port hash table with open addressing, byte-sum hash and fixed-stride probing.
//
// Input channel s_*: one transfer is one request. s_tuser holds the request kind
// (insert or lookup), s_tdata the 40-bit key and the 8-bit port to store.
// Output channel m_*: exactly one transfer per request. m_tuser holds the status
// (ok/found, not found, full), m_tdata the port found and the slot index.
// A request runs through one shared modulo adder under a small sequencer: the
// key bytes are summed modulo the table size, then one slot is probed per cycle,
// up to TABLE_SIZE slots, then the result moves to the output register. The gap
// between request transfers is set by the hash loop plus the probe loop over the
// slot array. With a free output register, m_tvalid rises together with s_tready.
// s_tready is high only while the sequencer is idle.
// The output register holds a finished result while the receiver stalls; the next
// request is still taken and processed, and waits for that register to drain.
// Reset clears the valid flags and the entry count, so the table starts empty;
// stored keys and ports need no reset.
`default_nettype none

module mac_port_hash_table (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [mpht_pkg::S_TDATA_W-1:0]   s_tdata,  // mac_key[39:0], port_in[47:40]
	input  wire logic                             s_tuser,  // req_type[0]
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [mpht_pkg::M_TDATA_W-1:0]        m_tdata,  // port_out[7:0], slot[11:8], zero[15:12]
	output logic [mpht_pkg::STAT_W-1:0]           m_tuser   // status[1:0]
);

	mpht_pkg::state_t state_q, state_d;
	mpht_pkg::ctl_t   ctl;

	// Request registers
	mpht_pkg::req_t                    req_q;
	logic [mpht_pkg::KEY_W-1:0]        key_q;
	logic [mpht_pkg::KEY_W-1:0]        hash_sh_q;
	logic [mpht_pkg::PORT_KEEP-1:0]    port_q;
	logic [mpht_pkg::BYTE_W-1:0]       byte_q;
	logic [mpht_pkg::SLOT_W-1:0]       slot_q;
	logic [mpht_pkg::SLOT_W-1:0]       k_q;

	// Table storage
	logic [mpht_pkg::KEY_W-1:0]        key_store_q  [mpht_pkg::TABLE_SIZE];
	logic [mpht_pkg::PORT_KEEP-1:0]    port_store_q [mpht_pkg::TABLE_SIZE];
	logic [mpht_pkg::TABLE_SIZE-1:0]   slot_valid_q;
	logic [mpht_pkg::CNT_W-1:0]        entry_count_q;

	// Result and output registers
	mpht_pkg::status_t                 res_status_q;
	logic [mpht_pkg::PORT_FIELD_W-1:0] res_port_q;
	logic [mpht_pkg::SLOT_FIELD_W-1:0] res_slot_q;
	logic                              m_tvalid_q;
	mpht_pkg::status_t                 m_status_q;
	logic [mpht_pkg::PORT_FIELD_W-1:0] m_port_q;
	logic [mpht_pkg::SLOT_FIELD_W-1:0] m_slot_q;

	// Probe status of the current slot
	logic                        is_insert;
	logic                        table_full;
	logic                        cur_valid;
	logic                        key_eq;
	logic                        last_probe;
	logic                        probe_end;
	logic                        out_free;
	logic [mpht_pkg::SLOT_W-1:0] add_b;
	logic [mpht_pkg::SLOT_W-1:0] add_sum;

	assign is_insert  = (req_q == mpht_pkg::REQ_INSERT);
	assign table_full = (entry_count_q >= mpht_pkg::CNT_W'(mpht_pkg::TABLE_SIZE));
	assign cur_valid  = slot_valid_q[slot_q];
	assign key_eq     = (key_store_q[slot_q] == key_q);
	assign last_probe = (k_q == mpht_pkg::SLOT_W'(mpht_pkg::TABLE_SIZE - 1));
	assign probe_end  = is_insert ? (table_full || !cur_valid || last_probe)
	                              : ((cur_valid && key_eq) || last_probe);
	assign out_free   = !m_tvalid_q || m_tready;

	// Shared modulo adder: key byte residue while hashing, probe stride while probing
	assign add_b   = (state_q == mpht_pkg::ST_HASH) ? mpht_pkg::byte_mod(hash_sh_q[7:0])
	                                                : mpht_pkg::SLOT_W'(mpht_pkg::STEP_MOD);
	assign add_sum = mpht_pkg::mod_add(slot_q, add_b);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mpht_pkg::ST_IDLE: begin
				if (s_tvalid)
					state_d = mpht_pkg::ST_HASH;
			end
			mpht_pkg::ST_HASH: begin
				if (byte_q == mpht_pkg::BYTE_W'(mpht_pkg::KEY_USE - 1))
					state_d = mpht_pkg::ST_PROBE;
			end
			mpht_pkg::ST_PROBE: begin
				if (probe_end)
					state_d = mpht_pkg::ST_DONE;
			end
			mpht_pkg::ST_DONE: begin
				if (out_free)
					state_d = mpht_pkg::ST_IDLE;
			end
			default: state_d = mpht_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ctl            = '0;
		ctl.res_status = mpht_pkg::RES_OK;
		case (state_q)
			mpht_pkg::ST_IDLE: begin
				ctl.take = s_tvalid;
			end
			mpht_pkg::ST_HASH: begin
				ctl.hash_en = 1'b1;
			end
			mpht_pkg::ST_PROBE: begin
				if (probe_end) begin
					ctl.res_en = 1'b1;
					if (is_insert) begin
						if (!table_full && !cur_valid) begin
							ctl.wr_en      = 1'b1;
							ctl.res_status = mpht_pkg::RES_OK;
						end else begin
							ctl.res_status = mpht_pkg::RES_FULL;
						end
					end else if (cur_valid && key_eq) begin
						ctl.res_hit    = 1'b1;
						ctl.res_status = mpht_pkg::RES_OK;
					end else begin
						ctl.res_status = mpht_pkg::RES_MISS;
					end
				end else begin
					ctl.probe_en = 1'b1;
				end
			end
			mpht_pkg::ST_DONE: begin
				ctl.out_load = out_free;
			end
			default: ctl = '0;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= mpht_pkg::ST_IDLE;
			slot_valid_q  <= '0;
			entry_count_q <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.wr_en) begin
				slot_valid_q[slot_q] <= 1'b1;
				entry_count_q        <= entry_count_q + 1'b1;
			end
			if (ctl.out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// Request, hash and probe datapath
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			req_q     <= mpht_pkg::req_t'(s_tuser);
			key_q     <= s_tdata[mpht_pkg::KEY_W-1:0];
			hash_sh_q <= s_tdata[mpht_pkg::KEY_W-1:0];
			port_q    <= s_tdata[mpht_pkg::KEY_FIELD_W +: mpht_pkg::PORT_KEEP];
			byte_q    <= '0;
			slot_q    <= '0;
			k_q       <= '0;
		end
		if (ctl.hash_en) begin
			slot_q    <= add_sum;
			hash_sh_q <= hash_sh_q >> 8;
			byte_q    <= byte_q + 1'b1;
		end
		if (ctl.probe_en) begin
			slot_q <= add_sum;
			k_q    <= k_q + 1'b1;
		end
	end

	// Table entry write
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			key_store_q[slot_q]  <= key_q;
			port_store_q[slot_q] <= port_q;
		end
	end

	// Result capture and output register
	always_ff @(posedge clk) begin
		if (ctl.res_en) begin
			res_status_q <= ctl.res_status;
			res_port_q   <= ctl.res_hit ? mpht_pkg::PORT_FIELD_W'(port_store_q[slot_q]) : '0;
			res_slot_q   <= (ctl.res_status == mpht_pkg::RES_OK)
			                ? mpht_pkg::SLOT_FIELD_W'(slot_q) : '0;
		end
		if (ctl.out_load) begin
			m_status_q <= res_status_q;
			m_port_q   <= res_port_q;
			m_slot_q   <= res_slot_q;
		end
	end

	assign s_tready = (state_q == mpht_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {{(mpht_pkg::M_TDATA_W - mpht_pkg::PORT_FIELD_W
	                     - mpht_pkg::SLOT_FIELD_W){1'b0}}, m_slot_q, m_port_q};

	// Entry count tracks the valid flags
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(entry_count_q) == 32'($countones(slot_valid_q)))
		else $error("entry count differs from number of valid slots");

	// Entry count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(entry_count_q) <= 32'(mpht_pkg::TABLE_SIZE))
		else $error("entry count above table size");

	// An insert only claims a free slot
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> !cur_valid)
		else $error("insert overwrote a valid slot");

	// Failed requests return zero port and slot
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != mpht_pkg::RES_OK) |-> (m_tdata == '0))
		else $error("failed request carries nonzero data");

	// A written slot is valid afterwards
	a_write_sets: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |=> (slot_valid_q[$past(slot_q)]))
		else $error("written slot not marked valid");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for mac_port_hash_table: request stream, inline table predictor, result checks.

module tb;

	localparam int RANDOM_REQS = 1000;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		mpht_pkg::req_t kind;
		logic [39:0]    key;
		logic [7:0]     port;
	} request_t;

	typedef struct {
		mpht_pkg::status_t status;
		logic [7:0]        port;
		logic [3:0]        slot;
	} answer_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [mpht_pkg::S_TDATA_W-1:0] s_tdata  = '0;  // mac_key[39:0], port_in[47:40]
	logic                           s_tuser  = 1'b0; // req_type[0]
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [mpht_pkg::M_TDATA_W-1:0] m_tdata;         // port_out[7:0], slot[11:8], zero[15:12]
	logic [mpht_pkg::STAT_W-1:0]    m_tuser;         // status[1:0]

	mac_port_hash_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Shadow copy of the table
	logic [39:0] mdl_key  [mpht_pkg::TABLE_SIZE];
	logic [7:0]  mdl_port [mpht_pkg::TABLE_SIZE];
	bit          mdl_used [mpht_pkg::TABLE_SIZE];
	int          mdl_count = 0;

	request_t    requests_q[$];
	answer_t     answers_due[$];
	logic [39:0] learned_keys[$];

	int reqs_taken = 0;
	int total_reqs = 0;
	int mismatches = 0;
	int n_stored = 0, n_full = 0, n_found = 0, n_missed = 0;
	int stall_cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit req_taken = 1'b0;

	// Idle phase: receiver-heavy gaps, then sender-heavy, then none
	wire [1:0] idle_phase = (reqs_taken < total_reqs / 3) ? 2'd0 :
		(reqs_taken < 2 * total_reqs / 3) ? 2'd1 : 2'd2;

	initial begin
		forever #2 clk = ~clk;
	end

	// Apply one request to the shadow table and return the answer it must produce
	function automatic answer_t table_answer(request_t r);
		answer_t a;
		int      sum;
		int      s;
		bit      done;
		a.port = '0;
		a.slot = '0;
		sum    = 0;
		done   = 1'b0;
		for (int i = 0; i < mpht_pkg::KEY_BYTES; i++)
			sum += r.key[8*i +: 8];
		if (r.kind == mpht_pkg::REQ_INSERT) begin
			a.status = mpht_pkg::RES_FULL;
			if (mdl_count < mpht_pkg::TABLE_SIZE) begin
				for (int k = 0; k < mpht_pkg::TABLE_SIZE && !done; k++) begin
					s = (sum + mpht_pkg::PROBE_STEP * k) % mpht_pkg::TABLE_SIZE;
					if (!mdl_used[s]) begin
						mdl_key[s]  = r.key;
						mdl_port[s] = r.port & 8'((1 << mpht_pkg::PORT_KEEP) - 1);
						mdl_used[s] = 1'b1;
						mdl_count++;
						a.status = mpht_pkg::RES_OK;
						a.slot   = 4'(s);
						done     = 1'b1;
					end
				end
			end
		end else begin
			a.status = mpht_pkg::RES_MISS;
			for (int k = 0; k < mpht_pkg::TABLE_SIZE && !done; k++) begin
				s = (sum + mpht_pkg::PROBE_STEP * k) % mpht_pkg::TABLE_SIZE;
				if (mdl_used[s] && mdl_key[s] == r.key) begin
					a.status = mpht_pkg::RES_OK;
					a.port   = mdl_port[s];
					a.slot   = 4'(s);
					done     = 1'b1;
				end
			end
		end
		return a;
	endfunction

	function automatic logic [39:0] rand_key();
		return {8'($urandom), 32'($urandom)};
	endfunction

	// Queue a request; remember keys that will land in the table
	task automatic add_request(mpht_pkg::req_t kind, logic [39:0] key, logic [7:0] port);
		request_t r;
		r.kind = kind;
		r.key  = key;
		r.port = port;
		requests_q.push_back(r);
		if (kind == mpht_pkg::REQ_INSERT && learned_keys.size() < mpht_pkg::TABLE_SIZE)
			learned_keys.push_back(key);
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("mismatch %0d at %0t: %s got %0h want %0h", mismatches, $realtime, what,
			got, want);
	endtask

	// Stimulus and end of run
	initial begin : stimulus
		logic [39:0] k;
		int          sum4;
		int          pick;

		// directed: empty-table miss, extremes, duplicate key, collisions, full table
		add_request(mpht_pkg::REQ_LOOKUP, '0, 8'h5A);
		add_request(mpht_pkg::REQ_INSERT, '0, 8'h00);
		add_request(mpht_pkg::REQ_INSERT, '1, 8'hFF);
		add_request(mpht_pkg::REQ_INSERT, '0, 8'hA5);
		add_request(mpht_pkg::REQ_LOOKUP, '0, 8'h00);
		add_request(mpht_pkg::REQ_LOOKUP, '1, 8'h00);
		add_request(mpht_pkg::REQ_INSERT, 40'h0A, 8'h3C);
		add_request(mpht_pkg::REQ_LOOKUP, 40'h0A, 8'hFF);
		add_request(mpht_pkg::REQ_LOOKUP, 40'h0A00, 8'h00);
		// six keys homed on slot 0 walk the whole probe chain
		repeat (6) begin
			k    = rand_key();
			sum4 = 0;
			for (int i = 0; i < 4; i++)
				sum4 += k[8*i +: 8];
			k[39:32] = 8'((10 - sum4 % 10) % 10 + 10 * $urandom_range(24, 0));
			add_request(mpht_pkg::REQ_INSERT, k, 8'($urandom));
		end
		add_request(mpht_pkg::REQ_INSERT, rand_key(), 8'($urandom));
		add_request(mpht_pkg::REQ_INSERT, '1, 8'h01);
		add_request(mpht_pkg::REQ_LOOKUP, learned_keys[mpht_pkg::TABLE_SIZE-1], 8'h00);
		add_request(mpht_pkg::REQ_LOOKUP, 40'h0A00, 8'hFF);
		add_request(mpht_pkg::REQ_LOOKUP, '1, 8'h00);

		// random: stored keys, same-sum rotations, fresh keys, refused inserts
		repeat (RANDOM_REQS) begin
			pick = $urandom_range(99);
			k    = learned_keys[$urandom_range(learned_keys.size() - 1)];
			if (pick < 45)
				add_request(mpht_pkg::REQ_LOOKUP, k, 8'($urandom));
			else if (pick < 65)
				add_request(mpht_pkg::REQ_LOOKUP, {k[31:0], k[39:32]}, 8'($urandom));
			else if (pick < 85)
				add_request(mpht_pkg::REQ_LOOKUP, rand_key(), 8'($urandom));
			else
				add_request(mpht_pkg::REQ_INSERT, rand_key(), 8'($urandom));
		end
		total_reqs = requests_q.size();

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		while (reqs_taken < total_reqs)
			@(negedge clk);
		while (answers_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("ran %0d requests: %0d inserts stored, %0d refused on a full table",
			total_reqs, n_stored, n_full);
		$display("lookups: %0d found, %0d missed; one %0d-cycle output hold-off applied",
			n_found, n_missed, HOLD_CYCLES);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Request driver: new transfer on the falling edge once the last one was taken
	always @(negedge clk) begin : drive_requests
		request_t r;
		if (arst_n && (!s_tvalid || req_taken)) begin
			if (requests_q.size() > 0 && $urandom_range(99) >=
				((idle_phase == 2'd0) ? 37 : (idle_phase == 2'd1) ? 51 : 0)) begin
				r = requests_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= r.kind;
				s_tdata  <= {r.port, r.key};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls plus one long hold-off halfway through
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && reqs_taken >= total_reqs / 2) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >=
				((idle_phase == 2'd0) ? 51 : (idle_phase == 2'd1) ? 37 : 0));
		end
	end

	// Monitor: predict on request transfers, check result transfers, watchdog
	always @(posedge clk) begin : check_results
		request_t r;
		answer_t  a;
		answer_t  w;
		if (arst_n) begin
			req_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				r.kind = mpht_pkg::req_t'(s_tuser);
				r.key  = s_tdata[39:0];
				r.port = s_tdata[47:40];
				a = table_answer(r);
				answers_due.push_back(a);
				reqs_taken++;
				if (r.kind == mpht_pkg::REQ_INSERT) begin
					if (a.status == mpht_pkg::RES_OK)
						n_stored++;
					else
						n_full++;
				end else if (a.status == mpht_pkg::RES_OK) begin
					n_found++;
				end else begin
					n_missed++;
				end
			end
			if (m_tvalid && m_tready) begin
				if (answers_due.size() == 0) begin
					report("result with none pending, tdata", 64'(m_tdata), 64'd0);
				end else begin
					w = answers_due.pop_front();
					if (m_tuser !== w.status)
						report("status", 64'(m_tuser), 64'(w.status));
					if (m_tdata[7:0] !== w.port)
						report("port_out", 64'(m_tdata[7:0]), 64'(w.port));
					if (m_tdata[11:8] !== w.slot)
						report("slot", 64'(m_tdata[11:8]), 64'(w.slot));
					if (m_tdata[15:12] !== 4'd0)
						report("tdata pad bits", 64'(m_tdata[15:12]), 64'd0);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
						stall_cycles, answers_due.size());
					$display("status: fail");
					$finish;
				end
			end
		end
	end

endmodule
